>>> src/ugm_pkg.sv
// Shared types, constants and codes for the glyph map block.
// No dependencies; used by every module in src.
`default_nettype none
package ugm_pkg;
  localparam int TableEntriesDef = 2048;

  typedef enum logic [1:0] {
    CMD_FEED = 2'd0,
    CMD_END  = 2'd1,
    CMD_LOOK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOLOAD = 2'd1,
    ST_FULL   = 2'd2
  } stat_t;

  localparam logic [15:0] CodeSep  = 16'hFFFF;
  localparam logic [15:0] CodeSeq  = 16'hFFFE;
  localparam logic [15:0] CodeRepl = 16'hFFFD;
  localparam logic [15:0] CodeQmark = 16'h003F;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] table_value;
    logic [20:0] code_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [8:0] glyph;
    logic [8:0] shown_glyph;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SRCH, S_SRCH_RD, S_SRCH_CMP, S_FOUND_RD, S_FOUND,
    S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_REPL2, S_DONE, S_OUT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic srch_init;   // start a lower-bound search on key
    logic srch_rd;     // read mem at mid
    logic srch_step;   // narrow lo/hi
    logic rd_idx;      // read mem at lo (found check)
    logic upd_glyph;   // lower glyph of the found entry
    logic shift_rd;    // read entry ptr-1, ptr--
    logic shift_wr;    // write it to ptr+1
    logic insert;      // write new entry at lo
    logic sep;         // separator
    logic seq;         // combining sequence start
    logic set_full;
    logic end_first;   // record result of 0xFFFD search
    logic key_qmark;   // second search key
    logic end_fin;     // finish replacement
    logic make_out;    // build result
    logic out_valid;   // result register is loaded
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       past_last;
    logic       is_sep;
    logic       is_seq;
    logic       in_seq;
    logic       srch_done;
    logic       hit;       // entry at lo matches key
    logic       empty;
    logic       full;
    logic       shift_done;
    logic       loaded;
  } sts_t;
endpackage
`default_nettype wire

>>> src/ugm_ctrl.sv
// Controller state machine of the glyph map block.
// Depends on ugm_pkg.
`default_nettype none
module ugm_ctrl import ugm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      busy,
  output logic      out_pending
);
  fsm_t state_r, state_nxt;
  logic end_pass_r, end_pass_nxt;  // second search of an end command

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      end_pass_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      end_pass_r <= end_pass_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    end_pass_nxt = end_pass_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_DECIDE;
      S_DECIDE: begin
        end_pass_nxt = 1'b0;
        case (sts.cmd)
          CMD_FEED: begin
            if (sts.past_last || sts.is_sep || sts.is_seq || sts.in_seq) state_nxt = S_DONE;
            else state_nxt = S_SRCH;
          end
          CMD_END: state_nxt = S_SRCH;
          CMD_LOOK: state_nxt = sts.loaded ? S_SRCH : S_DONE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_SRCH: state_nxt = sts.srch_done ? S_FOUND_RD : S_SRCH_RD;
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH;
      S_FOUND_RD: state_nxt = S_FOUND;
      S_FOUND: begin
        if (sts.cmd == CMD_FEED) begin
          if (sts.hit || sts.full) state_nxt = S_DONE;
          else state_nxt = sts.shift_done ? S_INSERT : S_SHIFT_RD;
        end else if (sts.cmd == CMD_END && !end_pass_r && !(sts.hit && !sts.empty)) begin
          state_nxt = S_REPL2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = sts.shift_done ? S_INSERT : S_SHIFT_RD;
      S_INSERT: state_nxt = S_DONE;
      S_REPL2: begin
        end_pass_nxt = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.load = (state_r == S_IDLE) && in_fire;
    case (state_r)
      S_DECIDE: begin
        ctl.sep = (sts.cmd == CMD_FEED) && !sts.past_last && sts.is_sep;
        ctl.seq = (sts.cmd == CMD_FEED) && !sts.past_last && sts.is_seq;
        ctl.srch_init = 1'b1;
      end
      S_SRCH: if (!sts.srch_done) ctl.srch_rd = 1'b1; else ctl.rd_idx = 1'b1;
      S_SRCH_CMP: ctl.srch_step = 1'b1;
      S_FOUND: begin
        if (sts.cmd == CMD_FEED) begin
          ctl.upd_glyph = sts.hit;
          ctl.set_full  = !sts.hit && sts.full;
        end
        if (sts.cmd == CMD_END) begin
          ctl.end_first = !end_pass_r;
          ctl.end_fin   = 1'b1;
        end
      end
      S_SHIFT_RD: ctl.shift_rd = 1'b1;
      S_SHIFT_WR: ctl.shift_wr = 1'b1;
      S_INSERT: ctl.insert = 1'b1;
      S_REPL2: ctl.key_qmark = 1'b1;
      S_DONE: ctl.make_out = 1'b1;
      default: ;
    endcase
    ctl.out_valid = (state_r == S_OUT);
  end

  assign busy        = (state_r != S_IDLE);
  assign out_pending = (state_r == S_OUT);
endmodule
`default_nettype wire

>>> src/ugm_dp.sv
// Datapath of the glyph map block: entry memory, search registers, parser state.
// Depends on ugm_pkg; driven by ugm_ctrl.
`default_nettype none
module ugm_dp import ugm_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wide_font,
  input  wire in_item_t  in_item,
  input  wire ctl_t      ctl,
  output sts_t           sts,
  output out_item_t      out_item
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;

  logic [15:0] codes_mem  [TABLE_ENTRIES];
  logic [8:0]  glyphs_mem [TABLE_ENTRIES];

  in_item_t    item_r;
  logic [20:0] key_r, key_nxt;
  logic [CW-1:0] lo_r, hi_r, mid_r, ptr_r, count_r;
  logic [9:0]  gcnt_r;
  logic        inseq_r, loaded_r, full_r;
  logic [8:0]  repl_r;
  logic [15:0] rd_code_r;
  logic [8:0]  rd_glyph_r;
  out_item_t   out_r, out_nxt;

  logic [9:0]    total;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we;
  logic [15:0]   wr_code;
  logic [8:0]    wr_glyph;
  logic          hit;
  logic          wr_glyph_only;
  logic [CW-1:0] mid_c;
  logic          lk_found;
  logic [8:0]    lk_glyph;

  assign total = wide_font ? 10'd512 : 10'd256;
  assign hit   = (lo_r < count_r) && ({5'd0, rd_code_r} == key_r);
  assign mid_c = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    rd_addr = mid_c[AW-1:0];
    if (ctl.rd_idx) rd_addr = lo_r[AW-1:0];
    if (ctl.shift_rd) rd_addr = AW'(ptr_r - 1'b1);
    we = 1'b0; wr_addr = lo_r[AW-1:0]; wr_code = rd_code_r; wr_glyph = rd_glyph_r;
    wr_glyph_only = 1'b0;
    if (ctl.upd_glyph && (gcnt_r < {1'b0, rd_glyph_r})) begin
      we = 1'b1; wr_glyph_only = 1'b1; wr_glyph = gcnt_r[8:0];
    end
    if (ctl.shift_wr) begin we = 1'b1; wr_addr = AW'(ptr_r + 1'b1); end
    if (ctl.insert) begin
      we = 1'b1; wr_code = item_r.table_value; wr_glyph = gcnt_r[8:0];
    end
    key_nxt = key_r;
    if (ctl.load) key_nxt = (in_item.command == CMD_LOOK) ? in_item.code_point
                          : (in_item.command == CMD_END) ? {5'd0, CodeRepl}
                          : {5'd0, in_item.table_value};
    if (ctl.key_qmark) key_nxt = {5'd0, CodeQmark};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      glyphs_mem[wr_addr] <= wr_glyph;
      if (!wr_glyph_only) codes_mem[wr_addr] <= wr_code;
    end
    rd_code_r  <= codes_mem[rd_addr];
    rd_glyph_r <= glyphs_mem[rd_addr];
  end

  // ptr starts from count when a search begins and steps down on each shift read
  always_ff @(posedge clk) begin
    if (ctl.load) item_r <= in_item;
    key_r <= key_nxt;
    if (ctl.srch_init || ctl.key_qmark) begin
      lo_r <= '0; hi_r <= count_r;
    end
    if (ctl.srch_rd) mid_r <= mid_c;
    if (ctl.srch_step) begin
      if ({5'd0, rd_code_r} < key_r) lo_r <= mid_r + 1'b1;
      else hi_r <= mid_r;
    end
    if (ctl.srch_init) ptr_r <= count_r;
    if (ctl.shift_rd) ptr_r <= ptr_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; gcnt_r <= '0; inseq_r <= 1'b0; loaded_r <= 1'b0;
      repl_r <= '0; full_r <= 1'b0;
    end else begin
      if (ctl.sep) begin gcnt_r <= gcnt_r + 1'b1; inseq_r <= 1'b0; end
      if (ctl.seq) inseq_r <= 1'b1;
      if (ctl.insert) count_r <= count_r + 1'b1;
      if (ctl.load) full_r <= 1'b0;
      if (ctl.set_full) full_r <= 1'b1;
      if (ctl.end_fin) begin
        loaded_r <= 1'b1;
        if (count_r == '0) begin
          // identity map: 0xFFFD never, '?' below the glyph count always
          repl_r <= 9'(CodeQmark);
        end else if (ctl.end_first) begin
          if (hit) repl_r <= rd_glyph_r;
        end else begin
          repl_r <= hit ? rd_glyph_r : 9'd0;
        end
      end
    end
  end

  always_comb begin
    out_nxt  = '0;
    lk_found = (count_r == '0) ? (key_r < {11'd0, total}) : hit;
    lk_glyph = (count_r == '0) ? key_r[8:0] : rd_glyph_r;
    if (!lk_found) lk_glyph = '0;
    if (item_r.command == CMD_FEED && full_r) out_nxt.status = ST_FULL;
    if (item_r.command == CMD_LOOK) begin
      if (!loaded_r) out_nxt.status = ST_NOLOAD;
      else begin
        out_nxt.found = lk_found;
        out_nxt.glyph = lk_glyph;
        if (lk_found && ({1'b0, lk_glyph} < total)) out_nxt.shown_glyph = lk_glyph;
        else if ({1'b0, repl_r} < total) out_nxt.shown_glyph = repl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.make_out) out_r <= out_nxt;
  end

  // the ptr-based shift runs until ptr reaches lo
  assign sts.cmd        = item_r.command;
  assign sts.past_last  = gcnt_r >= total;
  assign sts.is_sep     = item_r.table_value == CodeSep;
  assign sts.is_seq     = item_r.table_value == CodeSeq;
  assign sts.in_seq     = inseq_r;
  assign sts.srch_done  = !(lo_r < hi_r);
  assign sts.hit        = hit;
  assign sts.empty      = (count_r == '0);
  assign sts.full       = count_r >= CW'(TABLE_ENTRIES);
  assign sts.shift_done = (count_r == lo_r) || (ptr_r == lo_r);
  assign sts.loaded     = loaded_r;
  assign out_item       = out_r;
endmodule
`default_nettype wire

>>> src/unicode_glyph_map_top.sv
// Top level of the Unicode-to-glyph map block.
// Depends on ugm_pkg, ugm_ctrl and ugm_dp.
//
//  channel | ports                      | direction
//  --------+----------------------------+----------
//  input   | in_valid/in_ready/in_item  | in
//  result  | out_valid/out_ready/out_item | out
//  config  | cfg_we/cfg_wdata (wide_font) | in
//
// One item at a time. A feed that needs no search (separator, sequence
// start, skipped unit, ignored unit) goes straight to its result; a lookup
// or a merge runs a binary search of at most log2(entries)+1 steps;
// an insert also shifts the entries above it up by one; an end command
// runs one search and, if 0xFFFD misses, a second one for '?'.
// Reset clears counters and flags only; the entry memory is never cleared.
// A result waits in the output register until taken; the next item is
// accepted once it has left.
`default_nettype none
module unicode_glyph_map_top import ugm_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);
  ctl_t ctl;
  sts_t sts;
  logic busy, pending, wide_r;

  // hold the font width register
  always_ff @(posedge clk) begin
    if (!rst_n) wide_r <= 1'b0;
    else if (cfg_we) wide_r <= cfg_wdata;
  end

  assign in_ready  = !busy;
  assign out_valid = pending;

  ugm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready),
    .sts, .ctl, .busy, .out_pending(pending)
  );

  ugm_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .wide_font(wide_r), .in_item, .ctl, .sts, .out_item
  );
endmodule
`default_nettype wire

>>> tb/tb_unicode_glyph_map_top.sv
// Testbench for unicode_glyph_map_top: drives feed, end and lookup items,
// predicts every result with a behavioral glyph table and checks it.
// Depends on ugm_pkg and the RTL in src.
`default_nettype none

class glyph_map_board;
  int unsigned codes[$];
  int unsigned glyphs[$];
  int unsigned cnt_glyph;
  bit in_seq;
  bit loaded;
  int unsigned repl;
  bit wide;
  ugm_pkg::out_item_t pending[$];
  int errors;

  function void clear();
    codes.delete();
    glyphs.delete();
    cnt_glyph = 0;
    in_seq = 0;
    loaded = 0;
    repl = 0;
    wide = 0;
    pending.delete();
    errors = 0;
  endfunction

  function int unsigned total();
    return wide ? 512 : 256;
  endfunction

  function int unsigned lower_idx(int unsigned cp);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = codes.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (codes[mid] < cp) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function bit find_glyph(int unsigned cp, output int unsigned g);
    int unsigned i;
    g = 0;
    if (codes.size() == 0) begin
      if (cp < total()) begin
        g = cp;
        return 1;
      end
      return 0;
    end
    i = lower_idx(cp);
    if (i < codes.size() && codes[i] == cp) begin
      g = glyphs[i];
      return 1;
    end
    return 0;
  endfunction

  function bit [1:0] feed_unit(int unsigned v);
    int unsigned i;
    if (cnt_glyph >= total()) return ugm_pkg::ST_OK;
    if (v == ugm_pkg::CodeSep) begin
      cnt_glyph = (cnt_glyph + 1) & 10'h3FF;
      in_seq = 0;
      return ugm_pkg::ST_OK;
    end
    if (v == ugm_pkg::CodeSeq) begin
      in_seq = 1;
      return ugm_pkg::ST_OK;
    end
    if (in_seq) return ugm_pkg::ST_OK;
    i = lower_idx(v);
    if (i < codes.size() && codes[i] == v) begin
      if (cnt_glyph < glyphs[i]) glyphs[i] = cnt_glyph;
      return ugm_pkg::ST_OK;
    end
    if (codes.size() >= ugm_pkg::TableEntriesDef) return ugm_pkg::ST_FULL;
    codes.insert(i, v);
    glyphs.insert(i, cnt_glyph & 9'h1FF);
    return ugm_pkg::ST_OK;
  endfunction

  // Note an accepted input item and queue its expected result.
  function void note_item(ugm_pkg::in_item_t it);
    ugm_pkg::out_item_t r;
    int unsigned g;
    r = '0;
    case (it.command)
      ugm_pkg::CMD_FEED: r.status = feed_unit(it.table_value);
      ugm_pkg::CMD_END: begin
        loaded = 1;
        if (find_glyph(ugm_pkg::CodeRepl, g)) repl = g & 9'h1FF;
        else if (find_glyph(ugm_pkg::CodeQmark, g)) repl = g & 9'h1FF;
        else repl = 0;
      end
      ugm_pkg::CMD_LOOK: begin
        if (!loaded) r.status = ugm_pkg::ST_NOLOAD;
        else begin
          if (find_glyph(it.code_point, g)) begin
            r.found = 1;
            r.glyph = g & 9'h1FF;
          end
          if (r.found && r.glyph < total()) r.shown_glyph = r.glyph;
          else if (repl < total()) r.shown_glyph = repl;
        end
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(ugm_pkg::out_item_t got);
    ugm_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, got.status);
      errors++;
    end
    if (got.found !== e.found) begin
      $error("found exp %0d got %0d", e.found, got.found);
      errors++;
    end
    if (got.glyph !== e.glyph) begin
      $error("glyph exp %0d got %0d", e.glyph, got.glyph);
      errors++;
    end
    if (got.shown_glyph !== e.shown_glyph) begin
      $error("shown_glyph exp %0d got %0d", e.shown_glyph, got.shown_glyph);
      errors++;
    end
  endfunction
endclass

module tb_unicode_glyph_map_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ugm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  glyph_map_board board = new();
  int idle_cycles = 0;
  bit hold_long = 0;  // receiver holds off for a long stretch when set
  localparam int StallLimit = 200000;

  unicode_glyph_map_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Score handshakes at the edge; note the input before the result check so
  // a same-cycle pass-through would still find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_item(in_item);
      if (out_valid && out_ready) board.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: nothing accepted for too long ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= StallLimit) begin
      $display("[unicode_glyph_map_top] ERROR");
      $finish;
    end
  end

  // Receiver: stall on its own pattern; hold off entirely on request.
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hold_long) out_ready <= 0;
    else if (($urandom_range(0, 1023) / 128) % 3 == 0) out_ready <= 1;
    else out_ready <= (r < 65);
  end

  // Offer one item and hold it until accepted.
  task automatic send_item(input cmd_t c, input logic [15:0] tv, input logic [20:0] cp);
    in_item_t it;
    it.command = c;
    it.table_value = tv;
    it.code_point = cp;
    in_item <= it;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid after a burst and idle for a random gap.
  task automatic gap_after(input int unsigned n);
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);  // covers items that still finish work
  endtask

  task automatic write_wide(input bit w);
    cfg_wdata <= w;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    board.wide = w;
  endtask

  // Random content: mostly well-formed glyph records, some noise.
  task automatic random_item(input int unsigned bias_cp);
    int unsigned k;
    logic [15:0] v;
    logic [20:0] cp;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      case ($urandom_range(0, 9))
        0, 1: v = CodeSep;
        2: v = CodeSeq;
        3: v = CodeRepl;
        4: v = CodeQmark;
        5: v = 16'($urandom);
        default: v = 16'($urandom_range(0, bias_cp));
      endcase
      send_item(CMD_FEED, v, 21'($urandom));
    end else if (k < 54) begin
      send_item(CMD_END, 16'($urandom), 21'($urandom));
    end else if (k < 97) begin
      case ($urandom_range(0, 5))
        0: cp = 21'($urandom);
        1: cp = {$urandom_range(0, 1) ? 5'h1F : 5'h0, 16'hFFFD};
        default: cp = 21'($urandom_range(0, bias_cp));
      endcase
      send_item(CMD_LOOK, 16'($urandom), cp);
    end else begin
      send_item(CMD_NONE, 16'($urandom), 21'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned bias_cp);
    int unsigned burst;
    burst = $urandom_range(1, 12);
    repeat (n) begin
      random_item(bias_cp);
      if (--burst == 0) begin
        gap_after($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    int unsigned g;
    board.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: lookups before load, empty-table identity, extremes.
    send_item(CMD_LOOK, 16'h0, 21'h0);
    send_item(CMD_NONE, 16'hFFFF, 21'h1FFFFF);
    send_item(CMD_END, 16'h0, 21'h0);
    send_item(CMD_LOOK, 16'h0, 21'd255);
    send_item(CMD_LOOK, 16'h0, 21'd256);
    send_item(CMD_LOOK, 16'h0, 21'h1FFFFF);
    send_item(CMD_FEED, CodeQmark, 21'h0);
    send_item(CMD_FEED, 16'h0041, 21'h0);
    send_item(CMD_FEED, CodeSep, 21'h0);
    send_item(CMD_FEED, CodeSeq, 21'h0);
    send_item(CMD_FEED, 16'h0042, 21'h0);   // skipped in sequence
    send_item(CMD_FEED, CodeSep, 21'h0);
    send_item(CMD_FEED, 16'h0041, 21'h0);   // duplicate keeps lowest glyph
    send_item(CMD_FEED, 16'h0000, 21'h0);
    send_item(CMD_FEED, CodeRepl, 21'h0);
    send_item(CMD_END, 16'h0, 21'h0);
    send_item(CMD_END, 16'h0, 21'h0);       // repeated end
    send_item(CMD_LOOK, 16'h0, 21'h41);
    send_item(CMD_LOOK, 16'h0, 21'h42);
    send_item(CMD_LOOK, 16'h0, 21'h0FFFD);
    send_item(CMD_LOOK, 16'h0, 21'h1FFFD);

    // Hold the receiver off while the sender keeps offering items.
    fork
      begin
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      random_phase(10, 300);
    join
    drain();

    // Wide font, then fill the glyph counter past the last glyph.
    write_wide(1);
    random_phase(300, 600);
    drain();
    for (g = 0; g < 520; g++) send_item(CMD_FEED, CodeSep, 21'h0);
    send_item(CMD_FEED, 16'h0123, 21'h0);   // past last glyph: ignored
    send_item(CMD_END, 16'h0, 21'h0);
    random_phase(60, 600);
    drain();

    // Narrow font with glyphs now beyond the count.
    write_wide(0);
    random_phase(250, 600);
    drain();
    write_wide(1);
    random_phase(290, 70000);
    drain();

    if (board.pending.size() == 0 && board.errors == 0)
      $display("[unicode_glyph_map_top] OK");
    else
      $display("[unicode_glyph_map_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
